FILE: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked out of reset only.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/gwhs_pkg.sv
// Shared constants, codes and control structs of the waypoint steering block.
package gwhs_pkg;

  localparam int unsigned CORDIC_ITERATIONS = 24;
  localparam int unsigned CntW = 5;
  localparam int unsigned AddrW = 4;

  localparam logic signed [39:0] CORDIC_GAIN = 40'sh0026DD3B6A;
  localparam logic signed [33:0] EARTH_CIRC_CM = 34'sd4003017359;
  localparam logic signed [33:0] PI_Q29 = 34'sd1686629713;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  localparam logic [1:0] REG_TLAT = 2'd0;
  localparam logic [1:0] REG_TLON = 2'd1;
  localparam logic [1:0] REG_RAD  = 2'd2;

  localparam logic [3:0] MUL_NONE    = 4'd0;
  localparam logic [3:0] MUL_W_QZ    = 4'd1;
  localparam logic [3:0] MUL_QX_QY   = 4'd2;
  localparam logic [3:0] MUL_QY_QY   = 4'd3;
  localparam logic [3:0] MUL_QZ_QZ   = 4'd4;
  localparam logic [3:0] MUL_CL1_CL2 = 4'd5;
  localparam logic [3:0] MUL_ACC_S2  = 4'd6;
  localparam logic [3:0] MUL_S1_S1   = 4'd7;
  localparam logic [3:0] MUL_C_K     = 4'd8;
  localparam logic [3:0] MUL_SD_CL2  = 4'd9;
  localparam logic [3:0] MUL_CL1_SL2 = 4'd10;
  localparam logic [3:0] MUL_SL1_CL2 = 4'd11;
  localparam logic [3:0] MUL_TMP_CD  = 4'd12;
  localparam logic [3:0] MUL_E_PI    = 4'd13;

  localparam logic [4:0] ACT_NONE     = 5'd0;
  localparam logic [4:0] ACT_ACC_LOAD = 5'd1;
  localparam logic [4:0] ACT_ACC_ADD  = 5'd2;
  localparam logic [4:0] ACT_SY       = 5'd3;
  localparam logic [4:0] ACT_CY       = 5'd4;
  localparam logic [4:0] ACT_HEAD     = 5'd5;
  localparam logic [4:0] ACT_SC       = 5'd6;
  localparam logic [4:0] ACT_ACC_ASR  = 5'd7;
  localparam logic [4:0] ACT_CLAMP    = 5'd8;
  localparam logic [4:0] ACT_H        = 5'd9;
  localparam logic [4:0] ACT_G        = 5'd10;
  localparam logic [4:0] ACT_CANG     = 5'd11;
  localparam logic [4:0] ACT_ARRIVE   = 5'd12;
  localparam logic [4:0] ACT_AY       = 5'd13;
  localparam logic [4:0] ACT_TMP      = 5'd14;
  localparam logic [4:0] ACT_AX       = 5'd15;
  localparam logic [4:0] ACT_ERR      = 5'd16;
  localparam logic [4:0] ACT_RES      = 5'd17;

  localparam logic [2:0] ANG_HLAT = 3'd0;
  localparam logic [2:0] ANG_HLON = 3'd1;
  localparam logic [2:0] ANG_LAT  = 3'd2;
  localparam logic [2:0] ANG_TLAT = 3'd3;
  localparam logic [2:0] ANG_DLON = 3'd4;

  typedef struct packed {
    logic       load_in;
    logic [3:0] mul_sel;
    logic [4:0] act;
    logic       cor_start;
    logic       cor_vec;
    logic [2:0] ang_sel;
    logic       sq_start;
    logic       sq_sel;
    logic       out_load;
    logic       out_arr;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic arrived;
    logic cor_done;
    logic sq_done;
  } sts_t;

endpackage

FILE: rtl/core/gwhs_cordic.sv
// Iterative CORDIC: rotation for sine and cosine, vectoring for atan2.
module gwhs_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               vec_i,
  input  logic [31:0]        ang_i,
  input  logic signed [33:0] vy_i,
  input  logic signed [33:0] vx_i,
  output logic               done_o,
  output logic signed [33:0] sin_o,
  output logic signed [33:0] cos_o,
  output logic [31:0]        angle_o
);
  import gwhs_pkg::*;

  logic busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic signed [39:0] x_q, x_d, y_q, y_d;
  logic signed [33:0] z_q, z_d, zs;
  logic flip_q, flip_d, vec_q, vec_d;
  logic [31:0] base_q, base_d;
  logic signed [39:0] xsh, ysh, xn, yn;
  logic signed [33:0] tab;
  logic sigma;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    flip_d = flip_q;
    vec_d  = vec_q;
    base_d = base_q;
    zs     = 34'(signed'(ang_i));
    xsh    = x_q >>> cnt_q;
    ysh    = y_q >>> cnt_q;
    tab    = 34'(ATAN_TAB[cnt_q]);
    sigma  = vec_q ? y_q[39] : !z_q[33];
    if (start_i) begin
      cnt_d  = '0;
      vec_d  = vec_i;
      flip_d = 1'b0;
      base_d = '0;
      if (vec_i) begin
        z_d = '0;
        x_d = 40'(vx_i);
        y_d = 40'(vy_i);
        if (vy_i == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
          base_d = vx_i[33] ? 32'h80000000 : 32'h0;
        end else begin
          busy_d = 1'b1;
          if (vx_i[33]) begin
            x_d    = -40'(vx_i);
            y_d    = -40'(vy_i);
            base_d = 32'h80000000;
          end
        end
      end else begin
        busy_d = 1'b1;
        x_d    = CORDIC_GAIN;
        y_d    = '0;
        z_d    = zs;
        if (zs > 34'sd1073741824) begin
          z_d    = zs - 34'sd2147483648;
          flip_d = 1'b1;
        end else if (zs < -34'sd1073741824) begin
          z_d    = zs + 34'sd2147483648;
          flip_d = 1'b1;
        end
      end
    end else if (busy_q) begin
      if (sigma) begin
        x_d = x_q - ysh;
        y_d = y_q + xsh;
        z_d = z_q - tab;
      end else begin
        x_d = x_q + ysh;
        y_d = y_q - xsh;
        z_d = z_q + tab;
      end
      if (cnt_q == CntW'(CORDIC_ITERATIONS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
    vec_q  <= vec_d;
    base_q <= base_d;
  end

  assign xn      = -x_q;
  assign yn      = -y_q;
  assign done_o  = done_q;
  assign sin_o   = flip_q ? yn[33:0] : y_q[33:0];
  assign cos_o   = flip_q ? xn[33:0] : x_q[33:0];
  assign angle_o = base_q + z_q[31:0];

endmodule

FILE: rtl/core/gwhs_isqrt.sv
// Digit-by-digit floor square root, one result bit per cycle.
module gwhs_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [61:0] rad_i,
  output logic        done_o,
  output logic [30:0] root_o
);
  import gwhs_pkg::*;

  logic busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [61:0] rad_q, rad_d;
  logic [32:0] rem_q, rem_d;
  logic [30:0] root_q, root_d;
  logic [34:0] cur, trial, diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cur    = {rem_q, rad_q[61:60]};
    trial  = {2'b00, root_q, 2'b01};
    diff   = cur - trial;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[59:0], 2'b00};
      if (cur >= trial) begin
        rem_d  = diff[32:0];
        root_d = {root_q[29:0], 1'b1};
      end else begin
        rem_d  = cur[32:0];
        root_d = {root_q[29:0], 1'b0};
      end
      if (cnt_q == CntW'(30)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: rtl/core/gwhs_datapath.sv
// Datapath: registers, configuration, shared multiplier, CORDIC and square root.
module gwhs_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gwhs_pkg::cmd_t         cmd_i,
  output gwhs_pkg::sts_t         sts_o,
  input  logic                   mode_i,
  input  logic signed [31:0]     latitude_i,
  input  logic signed [31:0]     longitude_i,
  input  logic signed [15:0]     quat_w_i,
  input  logic signed [15:0]     quat_x_i,
  input  logic signed [15:0]     quat_y_i,
  input  logic signed [15:0]     quat_z_i,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [gwhs_pkg::AddrW-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output logic [13:0]            linear_speed_o,
  output logic signed [15:0]     angular_rate_o,
  output logic                   arrived_o
);
  import gwhs_pkg::*;

  logic mode_q;
  logic signed [31:0] lat_q, lon_q, tlat_q, tlon_q;
  logic signed [15:0] qw_q, qx_q, qy_q, qz_q;
  logic [15:0] rad_q;
  logic signed [33:0] s1_q, s2_q, sl1_q, cl1_q, sl2_q, cl2_q, sd_q, cd_q;
  logic signed [33:0] s1_d, s2_d, sl1_d, cl1_d, sl2_d, cl2_d, sd_d, cd_d;
  logic signed [33:0] ay_q, ay_d, ax_q, ax_d, tmp_q, tmp_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [67:0] p_q, w30, rs;
  logic signed [33:0] ma, mb;
  logic [23:0] head_q, head_d;
  logic arr_q, arr_d;
  logic signed [15:0] rate_q, rate_d;
  logic [15:0] absr;
  logic signed [32:0] dlat, dlon;
  logic [31:0] ang, hsum, desired, err;
  logic signed [64:0] csum;
  logic signed [63:0] t64;
  logic [61:0] sq_rad;
  logic cor_done, sq_done;
  logic signed [33:0] c_sin, c_cos;
  logic [31:0] c_angle;
  logic [30:0] sq_root;
  logic cfg_we;

  assign dlat = 33'(tlat_q) - 33'(lat_q);
  assign dlon = 33'(tlon_q) - 33'(lon_q);

  always_comb begin
    unique case (cmd_i.ang_sel)
      ANG_HLAT: ang = dlat[32:1];
      ANG_HLON: ang = dlon[32:1];
      ANG_LAT:  ang = lat_q;
      ANG_TLAT: ang = tlat_q;
      default:  ang = dlon[31:0];
    endcase
  end

  assign sq_rad = cmd_i.sq_sel ? (62'h1000000000000000 - acc_q[61:0]) : acc_q[61:0];

  gwhs_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cor_start),
    .vec_i   (cmd_i.cor_vec),
    .ang_i   (ang),
    .vy_i    (ay_q),
    .vx_i    (ax_q),
    .done_o  (cor_done),
    .sin_o   (c_sin),
    .cos_o   (c_cos),
    .angle_o (c_angle)
  );

  gwhs_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_W_QZ:    begin ma = 34'(qw_q);  mb = 34'(qz_q);  end
      MUL_QX_QY:   begin ma = 34'(qx_q);  mb = 34'(qy_q);  end
      MUL_QY_QY:   begin ma = 34'(qy_q);  mb = 34'(qy_q);  end
      MUL_QZ_QZ:   begin ma = 34'(qz_q);  mb = 34'(qz_q);  end
      MUL_CL1_CL2: begin ma = cl1_q;      mb = cl2_q;      end
      MUL_ACC_S2:  begin ma = acc_q[33:0]; mb = s2_q;      end
      MUL_S1_S1:   begin ma = s1_q;       mb = s1_q;       end
      MUL_C_K:     begin ma = tmp_q;      mb = EARTH_CIRC_CM; end
      MUL_SD_CL2:  begin ma = sd_q;       mb = cl2_q;      end
      MUL_CL1_SL2: begin ma = cl1_q;      mb = sl2_q;      end
      MUL_SL1_CL2: begin ma = sl1_q;      mb = cl2_q;      end
      MUL_TMP_CD:  begin ma = tmp_q;      mb = cd_q;       end
      MUL_E_PI:    begin ma = tmp_q;      mb = PI_Q29;     end
      default:     begin ma = '0;         mb = '0;         end
    endcase
  end

  assign w30 = p_q >>> 30;
  assign rs  = (p_q + 68'sh400000000000) >>> 47;

  always_comb begin
    s1_d = s1_q; s2_d = s2_q; sl1_d = sl1_q; cl1_d = cl1_q;
    sl2_d = sl2_q; cl2_d = cl2_q; sd_d = sd_q; cd_d = cd_q;
    ay_d = ay_q; ax_d = ax_q; tmp_d = tmp_q; acc_d = acc_q;
    head_d = head_q; arr_d = arr_q; rate_d = rate_q;
    hsum = c_angle + 32'd128;
    desired = 32'hC0000000 - c_angle;
    err = desired - {head_q, 8'h00};
    csum = 65'(acc_q) + 65'(p_q[63:0]);
    t64 = 64'sd1073741824 - (csum[63:0] <<< 1);
    unique case (cmd_i.act)
      ACT_ACC_LOAD: acc_d = p_q[63:0];
      ACT_ACC_ADD:  acc_d = csum[63:0];
      ACT_SY: begin
        ay_d  = {acc_q[32:0], 1'b0};
        acc_d = p_q[63:0];
      end
      ACT_CY:   ax_d = t64[33:0];
      ACT_HEAD: head_d = hsum[31:8];
      ACT_SC: begin
        unique case (cmd_i.ang_sel)
          ANG_HLAT: s1_d = c_sin;
          ANG_HLON: s2_d = c_sin;
          ANG_LAT:  begin sl1_d = c_sin; cl1_d = c_cos; end
          ANG_TLAT: begin sl2_d = c_sin; cl2_d = c_cos; end
          default:  begin sd_d = c_sin; cd_d = c_cos; end
        endcase
      end
      ACT_ACC_ASR: acc_d = w30[63:0];
      ACT_CLAMP: begin
        if (csum < 0) acc_d = '0;
        else if (csum > 65'sh1000000000000000) acc_d = 64'sh1000000000000000;
        else acc_d = csum[63:0];
      end
      ACT_H:    ay_d = {3'b000, sq_root};
      ACT_G:    ax_d = {3'b000, sq_root};
      ACT_CANG: tmp_d = {1'b0, c_angle, 1'b0};
      ACT_ARRIVE: begin
        if (p_q[63:0] < {16'h0000, rad_q, 32'h0}) arr_d = 1'b1;
      end
      ACT_AY:  ay_d = w30[33:0];
      ACT_TMP: tmp_d = w30[33:0];
      ACT_AX:  ax_d = 34'(acc_q - w30[63:0]);
      ACT_ERR: tmp_d = 34'(signed'(err));
      ACT_RES: rate_d = rs[15:0];
      default: ;
    endcase
  end

  assign absr = rate_q[15] ? 16'(-rate_q) : 16'(rate_q);

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      REG_TLAT: prdata = tlat_q;
      REG_TLON: prdata = tlon_q;
      REG_RAD:  prdata = {16'h0000, rad_q};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlat_q <= '0;
      tlon_q <= '0;
      rad_q  <= 16'd50;
      head_q <= '0;
      arr_q  <= 1'b0;
    end else begin
      head_q <= head_d;
      arr_q  <= arr_d;
      if (cfg_we) begin
        unique case (paddr[3:2])
          REG_TLAT: tlat_q <= pwdata;
          REG_TLON: tlon_q <= pwdata;
          REG_RAD:  rad_q  <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= mode_i;
      lat_q  <= latitude_i;
      lon_q  <= longitude_i;
      qw_q   <= quat_w_i;
      qx_q   <= quat_x_i;
      qy_q   <= quat_y_i;
      qz_q   <= quat_z_i;
    end
    p_q <= ma * mb;
    s1_q <= s1_d; s2_q <= s2_d; sl1_q <= sl1_d; cl1_q <= cl1_d;
    sl2_q <= sl2_d; cl2_q <= cl2_d; sd_q <= sd_d; cd_q <= cd_d;
    ay_q <= ay_d; ax_q <= ax_d; tmp_q <= tmp_d; acc_q <= acc_d;
    rate_q <= rate_d;
    if (cmd_i.out_load) begin
      arrived_o <= cmd_i.out_arr;
      if (cmd_i.out_arr) begin
        linear_speed_o <= '0;
        angular_rate_o <= '0;
      end else begin
        linear_speed_o <= (absr >= 16'd8192) ? 14'd0 : 14'(16'd8192 - absr);
        angular_rate_o <= rate_q;
      end
    end
  end

  assign sts_o = '{mode: mode_q, arrived: arr_q, cor_done: cor_done, sq_done: sq_done};

endmodule

FILE: rtl/core/gwhs_ctrl.sv
// Controller state machine sequencing the datapath per item.
module gwhs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  gwhs_pkg::sts_t sts_i,
  output gwhs_pkg::cmd_t cmd_o
);
  import gwhs_pkg::*;

  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_DISP   = 6'd1;
  localparam logic [5:0] S_Q1     = 6'd2;
  localparam logic [5:0] S_Q2     = 6'd3;
  localparam logic [5:0] S_Q3     = 6'd4;
  localparam logic [5:0] S_Q4     = 6'd5;
  localparam logic [5:0] S_Q5     = 6'd6;
  localparam logic [5:0] S_Q6     = 6'd7;
  localparam logic [5:0] S_QW     = 6'd8;
  localparam logic [5:0] S_SC     = 6'd9;
  localparam logic [5:0] S_SCW    = 6'd10;
  localparam logic [5:0] S_H1     = 6'd11;
  localparam logic [5:0] S_H2     = 6'd12;
  localparam logic [5:0] S_H3     = 6'd13;
  localparam logic [5:0] S_H4     = 6'd14;
  localparam logic [5:0] S_H5     = 6'd15;
  localparam logic [5:0] S_H6     = 6'd16;
  localparam logic [5:0] S_H7     = 6'd17;
  localparam logic [5:0] S_SQA    = 6'd18;
  localparam logic [5:0] S_SQAW   = 6'd19;
  localparam logic [5:0] S_SQB    = 6'd20;
  localparam logic [5:0] S_SQBW   = 6'd21;
  localparam logic [5:0] S_AT1    = 6'd22;
  localparam logic [5:0] S_AT1W   = 6'd23;
  localparam logic [5:0] S_K1     = 6'd24;
  localparam logic [5:0] S_K2     = 6'd25;
  localparam logic [5:0] S_K3     = 6'd26;
  localparam logic [5:0] S_B1     = 6'd27;
  localparam logic [5:0] S_B2     = 6'd28;
  localparam logic [5:0] S_B3     = 6'd29;
  localparam logic [5:0] S_B4     = 6'd30;
  localparam logic [5:0] S_B5     = 6'd31;
  localparam logic [5:0] S_B6     = 6'd32;
  localparam logic [5:0] S_AT2    = 6'd33;
  localparam logic [5:0] S_AT2W   = 6'd34;
  localparam logic [5:0] S_E1     = 6'd35;
  localparam logic [5:0] S_E2     = 6'd36;
  localparam logic [5:0] S_OUT    = 6'd37;
  localparam logic [5:0] S_OUTARR = 6'd38;

  logic [5:0] state_q, state_d;
  logic [2:0] sc_q, sc_d;
  logic ovld_q, ovld_d;
  logic out_free;

  assign out_free    = !ovld_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ovld_q;

  always_comb begin
    state_d = state_q;
    sc_d    = sc_q;
    ovld_d  = ovld_q && out_stall_i;
    cmd_o   = '0;
    cmd_o.ang_sel = sc_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        sc_d = ANG_HLAT;
        if (!sts_i.mode) state_d = S_Q1;
        else if (sts_i.arrived) state_d = S_OUTARR;
        else state_d = S_SC;
      end
      S_Q1: begin cmd_o.mul_sel = MUL_W_QZ; state_d = S_Q2; end
      S_Q2: begin
        cmd_o.mul_sel = MUL_QX_QY; cmd_o.act = ACT_ACC_LOAD; state_d = S_Q3;
      end
      S_Q3: begin
        cmd_o.mul_sel = MUL_QY_QY; cmd_o.act = ACT_ACC_ADD; state_d = S_Q4;
      end
      S_Q4: begin
        cmd_o.mul_sel = MUL_QZ_QZ; cmd_o.act = ACT_SY; state_d = S_Q5;
      end
      S_Q5: begin cmd_o.act = ACT_CY; state_d = S_Q6; end
      S_Q6: begin
        cmd_o.cor_start = 1'b1; cmd_o.cor_vec = 1'b1; state_d = S_QW;
      end
      S_QW: begin
        if (sts_i.cor_done) begin
          cmd_o.act = ACT_HEAD;
          state_d = S_IDLE;
        end
      end
      S_SC: begin cmd_o.cor_start = 1'b1; state_d = S_SCW; end
      S_SCW: begin
        if (sts_i.cor_done) begin
          cmd_o.act = ACT_SC;
          sc_d = sc_q + 1'b1;
          state_d = (sc_q == ANG_DLON) ? S_H1 : S_SC;
        end
      end
      S_H1: begin cmd_o.mul_sel = MUL_CL1_CL2; state_d = S_H2; end
      S_H2: begin cmd_o.act = ACT_ACC_ASR; state_d = S_H3; end
      S_H3: begin cmd_o.mul_sel = MUL_ACC_S2; state_d = S_H4; end
      S_H4: begin cmd_o.act = ACT_ACC_ASR; state_d = S_H5; end
      S_H5: begin cmd_o.mul_sel = MUL_ACC_S2; state_d = S_H6; end
      S_H6: begin
        cmd_o.act = ACT_ACC_LOAD; cmd_o.mul_sel = MUL_S1_S1; state_d = S_H7;
      end
      S_H7: begin cmd_o.act = ACT_CLAMP; state_d = S_SQA; end
      S_SQA: begin cmd_o.sq_start = 1'b1; state_d = S_SQAW; end
      S_SQAW: begin
        if (sts_i.sq_done) begin cmd_o.act = ACT_H; state_d = S_SQB; end
      end
      S_SQB: begin
        cmd_o.sq_start = 1'b1; cmd_o.sq_sel = 1'b1; state_d = S_SQBW;
      end
      S_SQBW: begin
        cmd_o.sq_sel = 1'b1;
        if (sts_i.sq_done) begin cmd_o.act = ACT_G; state_d = S_AT1; end
      end
      S_AT1: begin
        cmd_o.cor_start = 1'b1; cmd_o.cor_vec = 1'b1; state_d = S_AT1W;
      end
      S_AT1W: begin
        if (sts_i.cor_done) begin cmd_o.act = ACT_CANG; state_d = S_K1; end
      end
      S_K1: begin cmd_o.mul_sel = MUL_C_K; state_d = S_K2; end
      S_K2: begin cmd_o.act = ACT_ARRIVE; state_d = S_K3; end
      S_K3: state_d = sts_i.arrived ? S_OUTARR : S_B1;
      S_B1: begin cmd_o.mul_sel = MUL_SD_CL2; state_d = S_B2; end
      S_B2: begin
        cmd_o.act = ACT_AY; cmd_o.mul_sel = MUL_CL1_SL2; state_d = S_B3;
      end
      S_B3: begin
        cmd_o.act = ACT_ACC_ASR; cmd_o.mul_sel = MUL_SL1_CL2; state_d = S_B4;
      end
      S_B4: begin cmd_o.act = ACT_TMP; state_d = S_B5; end
      S_B5: begin cmd_o.mul_sel = MUL_TMP_CD; state_d = S_B6; end
      S_B6: begin cmd_o.act = ACT_AX; state_d = S_AT2; end
      S_AT2: begin
        cmd_o.cor_start = 1'b1; cmd_o.cor_vec = 1'b1; state_d = S_AT2W;
      end
      S_AT2W: begin
        if (sts_i.cor_done) begin cmd_o.act = ACT_ERR; state_d = S_E1; end
      end
      S_E1: begin cmd_o.mul_sel = MUL_E_PI; state_d = S_E2; end
      S_E2: begin cmd_o.act = ACT_RES; state_d = S_OUT; end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1; ovld_d = 1'b1; state_d = S_IDLE;
        end
      end
      S_OUTARR: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1; cmd_o.out_arr = 1'b1;
          ovld_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sc_q    <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sc_q    <= sc_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

FILE: rtl/core/gps_waypoint_heading_steering.sv
// Top level of the waypoint steering block.
// Input channel: in_valid_i/in_stall_o with mode_i selecting an orientation
// item (quaternion, stores yaw, no result) or a position item (lat/lon,
// gives one result with linear_speed_o, angular_rate_o, arrived_o).
// Output channel: out_valid_o/out_stall_i; the result sits in an output
// register, so the next item is taken while it waits.
// One item is worked at a time. An orientation item runs one atan2 pass of
// the shared CORDIC; a position item runs five sine/cosine passes and two
// atan2 passes of the shared CORDIC and two square roots. A position item
// after arrival skips these and answers with the arrived result.
// Target and arrival radius are to be written over the APB-style port
// only while idle; the block itself does not enforce it. Reset clears
// the stored heading, the arrived flag, and loads target 0,0 and radius
// 50 cm. When the receiver stalls, the result holds and a finished next
// result waits in the controller until the register frees.
module gps_waypoint_heading_steering (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic signed [31:0] latitude_i,
  input  logic signed [31:0] longitude_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [13:0]        linear_speed_o,
  output logic signed [15:0] angular_rate_o,
  output logic               arrived_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [gwhs_pkg::AddrW-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import gwhs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gwhs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gwhs_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (mode_i),
    .latitude_i     (latitude_i),
    .longitude_i    (longitude_i),
    .quat_w_i       (quat_w_i),
    .quat_x_i       (quat_x_i),
    .quat_y_i       (quat_y_i),
    .quat_z_i       (quat_z_i),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .linear_speed_o (linear_speed_o),
    .angular_rate_o (angular_rate_o),
    .arrived_o      (arrived_o)
  );

endmodule

FILE: rtl/core/gwhs_checker.sv
// Port-level checker for the waypoint steering block and its bind.
`include "assert_macros.svh"

module gwhs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [13:0]        linear_speed_o,
  input logic signed [15:0] angular_rate_o,
  input logic               arrived_o
);

  `ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped")
  `ASSERT_RST(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "item taken busy")
  `ASSERT_RST(a_arr_zero, clk_i, rst_ni, out_valid_o && arrived_o |-> linear_speed_o == 14'd0 && angular_rate_o == 16'sd0, "arrived cmd")
  `ASSERT_RST(a_speed_max, clk_i, rst_ni, out_valid_o |-> linear_speed_o <= 14'd8192, "speed above one")
  `ASSERT_ALL(a_rst_idle, clk_i, !rst_ni |=> !out_valid_o, "result valid in reset")

endmodule

bind gps_waypoint_heading_steering gwhs_checker u_gwhs_checker (.*);

FILE: sim/tb_gps_waypoint_heading_steering.sv
// Testbench for the waypoint steering block: random and directed items checked against a predictor.
module tb_gps_waypoint_heading_steering;
  timeunit 1ns;
  timeprecision 1ps;
  import gwhs_pkg::*;

  typedef struct {
    bit               mode;
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic signed [15:0] qw, qx, qy, qz;
  } fix_t;

  typedef struct {
    logic [13:0]        speed;
    logic signed [15:0] rate;
    logic               arrived;
  } cmd_out_t;

  class steer_scoreboard;
    bit [31:0] tgt_lat, tgt_lon;
    bit [15:0] radius;
    bit [23:0] heading;
    bit        reached;
    cmd_out_t  pending_cmds[$];
    int        errors;
    int        checked;
    int        n_orient, n_pos, n_arrived;

    function new();
      tgt_lat = 0;
      tgt_lon = 0;
      radius = 50;
      heading = 0;
      reached = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(int idx, bit [31:0] val);
      if (idx == REG_TLAT) tgt_lat = val;
      else if (idx == REG_TLON) tgt_lon = val;
      else if (idx == REG_RAD) radius = val[15:0];
    endfunction

    function void rotate(bit [31:0] ang, output longint s, output longint c);
      longint z, x, y, t;
      bit flip;
      z = longint'($signed(ang));
      x = 64'sh26DD3B6A;
      y = 0;
      flip = 0;
      if (z > (64'sd1 <<< 30)) begin
        z -= (64'sd1 <<< 31);
        flip = 1;
      end else if (z < -(64'sd1 <<< 30)) begin
        z += (64'sd1 <<< 31);
        flip = 1;
      end
      for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z -= longint'(ATAN_TAB[i]);
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z += longint'(ATAN_TAB[i]);
        end
        x = t;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    function bit [31:0] angle_of(longint y, longint x);
      bit [31:0] base;
      longint z, t;
      base = 0;
      z = 0;
      if (y == 0) return (x < 0) ? 32'h80000000 : 32'h0;
      if (x < 0) begin
        x = -x;
        y = -y;
        base = 32'h80000000;
      end
      for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
        if (y >= 0) begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z += longint'(ATAN_TAB[i]);
        end else begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z -= longint'(ATAN_TAB[i]);
        end
        x = t;
      end
      return base + z[31:0];
    endfunction

    function longint unsigned root_of(longint unsigned v);
      longint unsigned res, bv;
      res = 0;
      bv = 64'd1 << 62;
      while (bv > v) bv >>= 2;
      while (bv != 0) begin
        if (v >= res + bv) begin
          v -= res + bv;
          res = (res >> 1) + bv;
        end else begin
          res >>= 1;
        end
        bv >>= 2;
      end
      return res;
    endfunction

    function void note_input(fix_t it);
      longint s1, s2, sl1, cl1, sl2, cl2, sd, cd, dmy, dlat, dlon, cc, a, y, x, e, r;
      longint sy, cy;
      longint unsigned c;
      bit [31:0] yaw, desired, err;
      cmd_out_t res;
      if (!it.mode) begin
        sy = 2 * (longint'(it.qw) * longint'(it.qz) + longint'(it.qx) * longint'(it.qy));
        cy = (64'sd1 <<< 30) - 2 * (longint'(it.qy) * longint'(it.qy)
                                     + longint'(it.qz) * longint'(it.qz));
        yaw = angle_of(sy, cy) + 32'd128;
        heading = yaw[31:8];
        n_orient++;
        return;
      end
      n_pos++;
      res.speed = 0;
      res.rate = 0;
      res.arrived = 1;
      if (!reached) begin
        dlat = longint'($signed(tgt_lat)) - longint'(it.lat);
        dlon = longint'($signed(tgt_lon)) - longint'(it.lon);
        rotate(32'(dlat >>> 1), s1, dmy);
        rotate(32'(dlon >>> 1), s2, dmy);
        rotate(it.lat, sl1, cl1);
        rotate(tgt_lat, sl2, cl2);
        rotate(32'(dlon), sd, cd);
        cc = (cl1 * cl2) >>> 30;
        a = s1 * s1 + ((cc * s2) >>> 30) * s2;
        if (a < 0) a = 0;
        if (a > (64'sd1 <<< 60)) a = 64'sd1 <<< 60;
        c = 64'd2 * longint'(angle_of(longint'(root_of(a)),
                                      longint'(root_of((64'd1 << 60) - a))));
        if (c * 64'd4003017359 < ({48'd0, radius} << 32)) begin
          reached = 1;
          n_arrived++;
        end else begin
          y = (sd * cl2) >>> 30;
          x = ((cl1 * sl2) >>> 30) - ((((sl1 * cl2) >>> 30) * cd) >>> 30);
          desired = 32'hC0000000 - angle_of(y, x);
          err = desired - {heading, 8'd0};
          e = longint'($signed(err));
          r = (e * 64'sd1686629713 + (64'sd1 <<< 46)) >>> 47;
          if (r < 0) res.speed = (8192 + r > 0) ? 14'(8192 + r) : 14'd0;
          else res.speed = (8192 - r > 0) ? 14'(8192 - r) : 14'd0;
          res.rate = 16'(r);
          res.arrived = 0;
        end
      end
      pending_cmds.push_back(res);
    endfunction

    function void check_result(cmd_out_t got);
      cmd_out_t exp_cmd;
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected result speed=%0d rate=%0d arrived=%0d",
                 $time, got.speed, got.rate, got.arrived);
        errors++;
        return;
      end
      exp_cmd = pending_cmds.pop_front();
      checked++;
      if (got.speed !== exp_cmd.speed) begin
        $display("%0t: linear_speed expected %0d actual %0d", $time, exp_cmd.speed, got.speed);
        errors++;
      end
      if (got.rate !== exp_cmd.rate) begin
        $display("%0t: angular_rate expected %0d actual %0d", $time, exp_cmd.rate, got.rate);
        errors++;
      end
      if (got.arrived !== exp_cmd.arrived) begin
        $display("%0t: arrived expected %0d actual %0d", $time, exp_cmd.arrived, got.arrived);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic               mode_i = 0;
  logic signed [31:0] latitude_i = 0;
  logic signed [31:0] longitude_i = 0;
  logic signed [15:0] quat_w_i = 0;
  logic signed [15:0] quat_x_i = 0;
  logic signed [15:0] quat_y_i = 0;
  logic signed [15:0] quat_z_i = 0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic [13:0]        linear_speed_o;
  logic signed [15:0] angular_rate_o;
  logic               arrived_o;
  logic               psel = 0;
  logic               penable = 0;
  logic               pwrite = 0;
  logic [AddrW-1:0]   paddr = 0;
  logic [31:0]        pwdata = 0;
  logic [31:0]        prdata;
  logic               pready;

  steer_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  hold_req = 0;
  int  hold_left = 0;
  longint cycles = 0;
  localparam longint CycleLimit = 3000000;

  gps_waypoint_heading_steering DUT (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cmd_out_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.speed = linear_speed_o;
      got.rate = angular_rate_o;
      got.arrived = arrived_o;
      sb.check_result(got);
    end
  end

  task automatic write_reg(int idx, bit [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= AddrW'(4 * idx);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_item(fix_t it);
    in_valid_i <= 1'b1;
    mode_i <= it.mode;
    latitude_i <= it.lat;
    longitude_i <= it.lon;
    quat_w_i <= it.qw;
    quat_x_i <= it.qx;
    quat_y_i <= it.qy;
    quat_z_i <= it.qz;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_cmds.size() > 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic fix_t orient(int w, int x, int y, int z);
    fix_t it;
    it.mode = 0;
    it.lat = $urandom;
    it.lon = $urandom;
    it.qw = 16'(w);
    it.qx = 16'(x);
    it.qy = 16'(y);
    it.qz = 16'(z);
    return it;
  endfunction

  function automatic fix_t position(bit [31:0] lat, bit [31:0] lon);
    fix_t it;
    it = orient($urandom, $urandom, $urandom, $urandom);
    it.mode = 1;
    it.lat = lat;
    it.lon = lon;
    return it;
  endfunction

  // near: offsets around the target; close allows offsets small enough to arrive
  function automatic fix_t random_item(bit close);
    int kind;
    bit [31:0] dl, dn;
    kind = $urandom_range(9);
    if (kind < 4) return orient($urandom, $urandom, $urandom, $urandom);
    if (kind < 6) begin
      if ($urandom_range(7) == 0) return position($urandom, $urandom);
      return position(32'($signed($urandom_range(32'h80000000)) - 32'sh40000000), $urandom);
    end
    if (close) begin
      dl = $urandom_range(16'h3FFF);
      dn = $urandom_range(16'h3FFF);
    end else begin
      dl = $urandom_range(32'h03FFFFFF, 32'h00100000);
      dn = $urandom_range(32'h03FFFFFF);
    end
    if ($urandom_range(1)) dl = -dl;
    if ($urandom_range(1)) dn = -dn;
    return position(sb.tgt_lat + dl, sb.tgt_lon + dn);
  endfunction

  task automatic random_phase(int n, int mode_sel, bit close);
    case (mode_sel % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 88; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 88; end
      default: begin send_idle_pct = 20; stall_pct = 20; end
    endcase
    for (int i = 0; i < n; i++) begin
      send_item(random_item(close));
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(orient(0, 0, 0, 0));
    send_item(position(32'h40000000, 0));
    send_item(position(32'hC0000000, 32'h7FFFFFFF));
    send_item(position(0, 32'h80000000));
    send_item(orient(32767, 0, 0, 0));
    send_item(orient(-32768, -32768, -32768, -32768));
    send_item(orient(32767, 0, 0, 32767));
    send_item(orient(32767, 32767, 32767, 32767));
    send_item(position(32'h7FFFFFFF, 0));
    send_item(position(32'h80000000, 32'hFFFFFFFF));
    send_item(orient(0, 0, -32768, 0));
    send_item(orient(0, 0, 0, -32768));
    send_item(position(32'h00400000, 32'h00400000));
    send_item(position(32'hFFC00000, 32'hFFFFF000));
    drain();

    write_reg(REG_RAD, 0);
    send_item(position(0, 0));
    send_item(orient(-32768, 0, 0, 0));
    send_item(position(0, 0));
    drain();

    write_reg(REG_TLAT, 32'h40000000);
    write_reg(REG_TLON, 32'h00000000);
    write_reg(REG_RAD, 1);
    random_phase(150, 0, 0);
    drain();

    write_reg(REG_TLAT, 32'hC0000000);
    write_reg(REG_TLON, 32'h7FFFFFFF);
    write_reg(REG_RAD, 65535);
    random_phase(150, 1, 0);
    drain();

    write_reg(REG_TLAT, 32'($signed($urandom_range(32'h7FFFFFFF)) - 32'sh3FFFFFFF));
    write_reg(REG_TLON, 32'h80000000);
    // hold the receiver while the sender keeps offering items
    hold_req = 3000;
    random_phase(150, 2, 0);
    drain();

    write_reg(REG_TLAT, 32'($signed($urandom_range(32'h7FFFFFFF)) - 32'sh3FFFFFFF));
    write_reg(REG_TLON, $urandom);
    write_reg(REG_RAD, $urandom_range(65535, 1));
    random_phase(150, 3, 0);
    drain();

    write_reg(REG_TLAT, 32'($signed($urandom_range(32'h3FFFFFFF)) - 32'sh1FFFFFFF));
    write_reg(REG_TLON, $urandom);
    write_reg(REG_RAD, 65535);
    random_phase(100, 0, 0);
    random_phase(60, 3, 1);
    random_phase(40, 1, 0);
    drain();

    $display("Covered %0d orientation and %0d position items, %0d results checked.",
             sb.n_orient, sb.n_pos, sb.checked);
    $display("Targets at the poles and longitude extremes, radius 0..65535, arrival %0s.",
             sb.reached ? "reached" : "not reached");
    if (sb.errors == 0 && sb.pending_cmds.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
